// ----- design/tkrt_pkg.sv -----
// Shared types, constants and helper functions for the top-K ratio tracker.
// Used by tkrt_cfg, tkrt_cell, tkrt_tree and top_k_ratio_tracker; no dependencies.
package tkrt_pkg;

  localparam int unsigned VAL_W   = 32;   // Q16.16 ratio width
  localparam int unsigned NREP_W  = 14;   // replication count width
  localparam int unsigned NUM_Q   = 5;    // quantile taps: 0.05 .. 0.00001
  localparam int unsigned RANK_W  = 10;   // largest rank is 16384 / 20 = 819
  localparam int unsigned K_W     = 10;   // kept count never exceeds 512
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned DIV_W   = 15;   // holds replication count + 20
  localparam int unsigned TREE_FAN = 8;

  localparam logic [NREP_W-1:0] NREP_RESET = NREP_W'(999);

  // Register word index decoded from paddr[2]
  localparam logic REG_NUM_REPS = 1'b0;

  // Bias that turns floor division into a round-up by twenty
  localparam logic [DIV_W-1:0] ROUND_UP_BIAS = DIV_W'(19);

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_CLEAR = 1'b1
  } action_t;

  // Reciprocals for exact floor(x / D), x < 2^15, D = 20, 100, 1000, 10000, 100000:
  // M = ceil(2^s / D) with s = 15 + ceil(log2 D).
  localparam logic [16:0] RANK_RECIP [NUM_Q] = '{
    17'd52429, 17'd41944, 17'd33555, 17'd53688, 17'd42950
  };
  localparam int unsigned RANK_SHIFT [NUM_Q] = '{20, 22, 25, 29, 32};

  // Decoded configuration seen by every cell
  typedef struct packed {
    logic [K_W-1:0]                kept;
    logic [NUM_Q-1:0][RANK_W-1:0]  rank;
    logic [NUM_Q-1:0]              rank_ok;
  } ranked_cfg_t;

  // Per-item command to the cell row
  typedef struct packed {
    logic add;
    logic clear;
  } cell_op_t;

  // What one cell offers to the select tree
  typedef struct packed {
    logic                        hit;
    logic [NUM_Q-1:0][VAL_W-1:0] value;
  } tap_t;

  // floor(x / D_j) by reciprocal multiply
  function automatic logic [DIV_W-1:0] div_rank(input logic [DIV_W-1:0] x,
                                                input int unsigned j);
    logic [47:0] prod;
    prod = 48'(x) * 48'(RANK_RECIP[j]);
    return DIV_W'(prod >> RANK_SHIFT[j]);
  endfunction

  // Kept count and quantile ranks for a replication count
  function automatic ranked_cfg_t derive_cfg(input logic [NREP_W-1:0] nrep,
                                             input int unsigned cap);
    ranked_cfg_t c;
    logic [DIV_W-1:0] x;
    logic [DIV_W-1:0] q;
    x = DIV_W'(nrep) + DIV_W'(1);
    q = div_rank(x + ROUND_UP_BIAS, 0);
    if (32'(q) > cap) begin
      q = DIV_W'(cap);
    end
    c.kept = K_W'(q);
    for (int j = 0; j < NUM_Q; j++) begin
      q = div_rank(x, j);
      c.rank[j]    = RANK_W'(q);
      c.rank_ok[j] = (q != '0) && (32'(q) <= 32'(c.kept));
    end
    return c;
  endfunction

  // Register levels of the select tree (at least one)
  function automatic int unsigned tree_levels(input int unsigned n);
    int unsigned c;
    int unsigned l;
    c = n;
    l = 0;
    while (c > 1) begin
      c = (c + TREE_FAN - 1) / TREE_FAN;
      l++;
    end
    if (l == 0) begin
      l = 1;
    end
    return l;
  endfunction

  // Node count at a tree level; level 0 is the leaves
  function automatic int unsigned level_nodes(input int unsigned n, input int unsigned l);
    int unsigned c;
    c = n;
    for (int unsigned i = 0; i < l; i++) begin
      c = (c + TREE_FAN - 1) / TREE_FAN;
    end
    return c;
  endfunction

endpackage

// ----- design/tkrt_cfg.sv -----
// APB-style register block: holds the replication count and decodes it into
// the kept count and quantile ranks. Depends on tkrt_pkg.
module tkrt_cfg import tkrt_pkg::*; #(
  parameter int unsigned CAPACITY = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ranked_cfg_t        cfg,
  output logic               clear
);

  logic [NREP_W-1:0] nrep_r;
  ranked_cfg_t       cfg_r;
  logic              wr_en;

  // Decode a completed write to the replication count
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_NUM_REPS);

  // Hold the count and its decoded form; both change on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrep_r <= NREP_RESET;
      cfg_r  <= derive_cfg(NREP_RESET, CAPACITY);
    end else if (wr_en) begin
      nrep_r <= pwdata[NREP_W-1:0];
      cfg_r  <= derive_cfg(pwdata[NREP_W-1:0], CAPACITY);
    end
  end

  // Return the count on reads of its word, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_NUM_REPS) begin
      prdata = PDATA_W'(nrep_r);
    end
  end

  // A new count starts a fresh list
  assign clear = wr_en;
  assign cfg   = cfg_r;

endmodule

// ----- design/tkrt_cell.sv -----
// One rank of the sorted list: compares its entry with the incoming ratio,
// takes the ratio or its upper neighbor's entry, and offers taps. Depends on tkrt_pkg.
module tkrt_cell import tkrt_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ranked_cfg_t      cfg,
  input  cell_op_t         op,
  input  logic [VAL_W-1:0] ratio,
  input  logic             prev_lt,
  input  logic [VAL_W-1:0] prev_val,
  output logic             lt,
  output logic [VAL_W-1:0] val,
  output tap_t             tap
);

  logic [VAL_W-1:0] val_r, val_nxt;
  logic             hit_r, hit_nxt;
  logic             kept;

  // Only ranks below the kept count take part
  assign kept = 32'(IDX) < 32'(cfg.kept);
  assign lt   = kept && (val_r < ratio);

  // Shift down behind the insertion point, take the ratio at it
  always_comb begin
    val_nxt = val_r;
    hit_nxt = hit_r;
    if (op.clear) begin
      val_nxt = '0;
      hit_nxt = 1'b0;
    end else if (op.add) begin
      hit_nxt = lt;
      if (kept && prev_lt) begin
        val_nxt = prev_val;
      end else if (lt) begin
        val_nxt = ratio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      hit_r <= 1'b0;
    end else begin
      val_r <= val_nxt;
      hit_r <= hit_nxt;
    end
  end

  // Offer the entry on each quantile tap whose rank lands here
  always_comb begin
    tap.hit = hit_r;
    for (int j = 0; j < NUM_Q; j++) begin
      if (cfg.rank_ok[j] && (32'(cfg.rank[j]) == 32'(IDX) + 32'd1)) begin
        tap.value[j] = val_r;
      end else begin
        tap.value[j] = '0;
      end
    end
  end

  assign val = val_r;

endmodule

// ----- design/tkrt_tree.sv -----
// Registered eight-way OR tree that gathers the one selected entry per tap
// and the accept flag from the cell row. Depends on tkrt_pkg.
module tkrt_tree import tkrt_pkg::*; #(
  parameter int unsigned N = 512
) (
  input  logic clk,
  input  logic en,
  input  tap_t leaf [N],
  output tap_t root
);

  localparam int unsigned LVLS   = tree_levels(N);
  localparam int unsigned NODES1 = level_nodes(N, 1);

  tap_t lvl [1:LVLS][NODES1];

  for (genvar l = 1; l <= LVLS; l++) begin : g_lvl
    localparam int unsigned PREV = level_nodes(N, l - 1);
    localparam int unsigned CUR  = level_nodes(N, l);
    for (genvar j = 0; j < CUR; j++) begin : g_node
      tap_t kid [TREE_FAN];
      tap_t sum;
      for (genvar c = 0; c < TREE_FAN; c++) begin : g_kid
        if (TREE_FAN * j + c < PREV) begin : g_used
          if (l == 1) begin : g_leaf
            assign kid[c] = leaf[TREE_FAN * j + c];
          end else begin : g_inner
            assign kid[c] = lvl[l-1][TREE_FAN * j + c];
          end
        end else begin : g_pad
          assign kid[c] = '0;
        end
      end
      // Merge the children; at most one carries a nonzero tap value
      always_comb begin
        sum = '0;
        for (int c = 0; c < TREE_FAN; c++) begin
          sum = sum | kid[c];
        end
      end
      // Advance together with the result pipeline
      always_ff @(posedge clk) begin
        if (en) begin
          lvl[l][j] <= sum;
        end
      end
    end
  end

  assign root = lvl[LVLS][0];

endmodule

// ----- design/top_k_ratio_tracker.sv -----
// Top-K ratio tracker: sorted insertion list as a row of CAPACITY cells.
// The result passes the cell registers and then the registered eight-way select
// tree behind the cell row. Throughput: one request per cycle while the output
// is not stalled; all cells compare and shift in the accept cycle.
// Reset: every entry zero, replication count 999; no clearing pass.
// Depends on tkrt_pkg, tkrt_cfg, tkrt_cell and tkrt_tree.
module top_k_ratio_tracker import tkrt_pkg::*; #(
  parameter int unsigned CAPACITY = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [0:0]         in_action,
  input  logic [VAL_W-1:0]   in_ratio,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic               out_alpha05_valid,
  output logic [VAL_W-1:0]   out_alpha05_value,
  output logic               out_alpha01_valid,
  output logic [VAL_W-1:0]   out_alpha01_value,
  output logic               out_alpha001_valid,
  output logic [VAL_W-1:0]   out_alpha001_value,
  output logic               out_alpha0001_valid,
  output logic [VAL_W-1:0]   out_alpha0001_value,
  output logic               out_alpha00001_valid,
  output logic [VAL_W-1:0]   out_alpha00001_value,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned LVLS = tree_levels(CAPACITY);

  ranked_cfg_t      cfg;
  logic             cfg_clear;
  cell_op_t         op;
  logic             adv;
  logic             in_accept;
  logic [LVLS:0]    pv_r, pv_nxt;
  logic             lt_w  [CAPACITY];
  logic [VAL_W-1:0] val_w [CAPACITY];
  tap_t             tap_w [CAPACITY];
  tap_t             root;

  tkrt_cfg #(.CAPACITY(CAPACITY)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clear   (cfg_clear)
  );

  // Hold everything while a finished result waits on a stalled output
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;

  // Broadcast the request to the cell row
  assign op.add   = in_accept && (in_action == ACT_ADD);
  assign op.clear = cfg_clear || (in_accept && (in_action == ACT_CLEAR));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             p_lt;
    logic [VAL_W-1:0] p_val;
    if (i == 0) begin : g_head
      assign p_lt  = 1'b0;
      assign p_val = '0;
    end else begin : g_body
      assign p_lt  = lt_w[i-1];
      assign p_val = val_w[i-1];
    end
    tkrt_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (cfg),
      .op       (op),
      .ratio    (in_ratio),
      .prev_lt  (p_lt),
      .prev_val (p_val),
      .lt       (lt_w[i]),
      .val      (val_w[i]),
      .tap      (tap_w[i])
    );
  end

  tkrt_tree #(.N(CAPACITY)) u_tree (
    .clk  (clk),
    .en   (adv),
    .leaf (tap_w),
    .root (root)
  );

  // Track which tree levels carry a live request
  always_comb begin
    pv_nxt = pv_r;
    if (adv) begin
      pv_nxt = {pv_r[LVLS-1:0], in_accept};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= pv_nxt;
    end
  end

  // Drive the result from the tree root
  assign out_valid            = pv_r[LVLS];
  assign out_accepted         = root.hit;
  assign out_alpha05_valid    = cfg.rank_ok[0];
  assign out_alpha05_value    = root.value[0];
  assign out_alpha01_valid    = cfg.rank_ok[1];
  assign out_alpha01_value    = root.value[1];
  assign out_alpha001_valid   = cfg.rank_ok[2];
  assign out_alpha001_value   = root.value[2];
  assign out_alpha0001_valid  = cfg.rank_ok[3];
  assign out_alpha0001_value  = root.value[3];
  assign out_alpha00001_valid = cfg.rank_ok[4];
  assign out_alpha00001_value = root.value[4];

  // Kept count respects the cell row length
  a_kept_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cfg.kept) <= CAPACITY)
    else $error("kept count exceeds cell row");

  // A count write leaves a fresh, empty list
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_NUM_REPS))
      |=> (val_w[0] == '0))
    else $error("store not cleared by count write");

  // A missing rank reads as zero
  a_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_alpha05_valid || out_alpha05_value == '0) &&
                   (out_alpha01_valid || out_alpha01_value == '0) &&
                   (out_alpha001_valid || out_alpha001_value == '0) &&
                   (out_alpha0001_valid || out_alpha0001_value == '0) &&
                   (out_alpha00001_valid || out_alpha00001_value == '0)))
    else $error("invalid rank carries a value");

  for (genvar i = 1; i < CAPACITY; i++) begin : g_chk
    // Kept entries stay in descending order
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (32'(i) < 32'(cfg.kept)) |-> (val_w[i-1] >= val_w[i]))
      else $error("kept entries out of order");
    // Entries past the kept count never fill
    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
      (32'(i) >= 32'(cfg.kept)) |-> (val_w[i] == '0))
      else $error("entry beyond kept count is nonzero");
  end

endmodule
